// ===== src/oahm_pkg.sv =====
// ---------------------------------------------------------------------------
// oahm_pkg: shared types and constants
// Request codes, key markers and the front-to-back queue item for the hash map.
// ---------------------------------------------------------------------------
package oahm_pkg;

    localparam int KeyW  = 64;
    localparam int DataW = 64;
    localparam int ReqW  = 3;

    localparam logic [ReqW-1:0] REQ_INSERT  = 3'd0;
    localparam logic [ReqW-1:0] REQ_REPLACE = 3'd1;
    localparam logic [ReqW-1:0] REQ_REMOVE  = 3'd2;
    localparam logic [ReqW-1:0] REQ_FIND    = 3'd3;
    localparam logic [ReqW-1:0] REQ_CLEAR   = 3'd4;

    localparam logic [KeyW-1:0] KEY_EMPTY = '0;
    localparam logic [KeyW-1:0] KEY_TOMB  = '1;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REPLACE,
        OP_REMOVE,
        OP_FIND,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [KeyW-1:0] key;
        logic [DataW-1:0] data;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK_RD,
        ST_LOOK_CHK,
        ST_DECIDE,
        ST_PLACE_RD,
        ST_PLACE_CHK,
        ST_RS_CLR,
        ST_RS_SCAN_RD,
        ST_RS_SCAN_CHK,
        ST_RS_PRB_RD,
        ST_RS_PRB_CHK,
        ST_RS_COPY_RD,
        ST_RS_COPY_WR,
        ST_OUT
    } t_state;

    function automatic logic [KeyW-1:0] mix(input logic [KeyW-1:0] k);
        return k ^ (k >> 13);
    endfunction

endpackage

// ===== src/oahm_front.sv =====
// ---------------------------------------------------------------------------
// oahm_front: request intake
// Classifies each request item and queues it for the table engine.
// ---------------------------------------------------------------------------
module oahm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [135:0]      s_axis_tdata,  // req_type[2:0], key[66:3], write_data[130:67]
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output oahm_pkg::t_cmd    o_cmd
);
    import oahm_pkg::*;

    localparam int Depth = 2;

    t_cmd      r_q [Depth];
    logic      r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd      w_cmd;
    logic [ReqW-1:0] w_req;
    logic [KeyW-1:0] w_key;
    logic      w_legal;
    logic      w_push, w_pop;

    // classify request
    always_comb begin
        w_req   = s_axis_tdata[ReqW-1:0];
        w_key   = s_axis_tdata[ReqW +: KeyW];
        w_legal = (w_key != KEY_EMPTY) && (w_key != KEY_TOMB);
        w_cmd.key  = w_key;
        w_cmd.data = s_axis_tdata[ReqW+KeyW +: DataW];
        w_cmd.op   = OP_NONE;
        if (w_req == REQ_CLEAR) begin
            w_cmd.op = OP_CLEAR;
        end else if (w_legal) begin
            unique case (w_req)
                REQ_INSERT:  w_cmd.op = OP_INSERT;
                REQ_REPLACE: w_cmd.op = OP_REPLACE;
                REQ_REMOVE:  w_cmd.op = OP_REMOVE;
                REQ_FIND:    w_cmd.op = OP_FIND;
                default:     w_cmd.op = OP_NONE;
            endcase
        end
    end

    assign s_axis_tready = (r_cnt != 2'(Depth));
    assign o_cmd_valid   = (r_cnt != 2'd0);
    assign o_cmd         = r_q[r_rp];
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign w_pop         = o_cmd_valid && i_cmd_ready;

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

endmodule

// ===== src/oahm_back.sv =====
// ---------------------------------------------------------------------------
// oahm_back: table engine
// Walks probe chains, updates slots and resizes the table through scratch.
// ---------------------------------------------------------------------------
module oahm_back #(
    parameter int MAX_SLOTS_LOG2 = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  oahm_pkg::t_cmd i_cmd,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [71:0]    m_axis_tdata
);
    import oahm_pkg::*;

    localparam int Slots = 1 << MAX_SLOTS_LOG2;
    localparam int AW    = MAX_SLOTS_LOG2;
    localparam int CW    = MAX_SLOTS_LOG2 + 1;
    localparam int LW    = $clog2(MAX_SLOTS_LOG2 + 1);

    // main table and scratch table
    logic [KeyW-1:0]  r_mkey [Slots];
    logic [DataW-1:0] r_mval [Slots];
    logic [KeyW-1:0]  r_skey [Slots];
    logic [DataW-1:0] r_sval [Slots];

    t_state r_st, n_st;
    t_cmd   r_cmd;
    logic [LW-1:0] r_lg, r_newlg;
    logic [CW-1:0] r_live, r_never;
    logic [KeyW-1:0] r_p, r_b;
    logic [CW+4:0] r_n;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_i;
    logic [KeyW-1:0] r_mk_rd, r_sk_rd, r_rkey;
    logic [DataW-1:0] r_mv_rd, r_sv_rd, r_rval;
    logic r_from_place;
    logic [DataW-1:0] r_res;
    logic r_found, r_fail, r_ovalid;

    logic [CW-1:0]  w_size;
    logic [AW-1:0]  w_mask, w_slot;
    logic [CW-1:0]  w_news;
    logic [AW-1:0]  w_nmask, w_nslot;
    logic [CW+4:0]  w_bound, w_nbound;
    logic [KeyW-1:0] w_h, w_rh;

    assign w_size   = CW'(1) << r_lg;
    assign w_mask   = AW'(w_size - CW'(1));
    assign w_news   = CW'(1) << r_newlg;
    assign w_nmask  = AW'(w_news - CW'(1));
    assign w_slot   = AW'(r_p) & w_mask;
    assign w_nslot  = AW'(r_p) & w_nmask;
    assign w_bound  = (CW+5)'(w_size) + (CW+5)'(16);
    assign w_nbound = (CW+5)'(w_news) + (CW+5)'(16);
    assign w_h      = mix(r_cmd.key);
    assign w_rh     = mix(r_rkey);

    // a new item is taken only once the previous result has left
    assign o_cmd_ready   = (r_st == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_fail, r_found, r_res};

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_INIT:        n_st = (r_i == CW'(Slots - 1)) ? ST_IDLE : ST_INIT;
            default:        n_st = r_st;
        endcase
    end

    // sequencer; all datapath updates are here, next state from above for
    // the clearing pass only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_INIT;
            r_i      <= '0;
            r_lg     <= LW'(1);
            r_live   <= '0;
            r_never  <= CW'(2);
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                ST_INIT: begin
                    // clearing pass over the main table
                    r_mkey[AW'(r_i)] <= KEY_EMPTY;
                    r_mval[AW'(r_i)] <= '0;
                    r_i  <= r_i + CW'(1);
                    r_st <= n_st;
                end
                ST_IDLE: begin
                    if (i_cmd_valid && !r_ovalid) begin
                        r_cmd   <= i_cmd;
                        r_res   <= '0;
                        r_found <= 1'b0;
                        r_fail  <= 1'b0;
                        r_p     <= mix(i_cmd.key);
                        r_b     <= mix(i_cmd.key);
                        r_n     <= '0;
                        r_i     <= '0;
                        unique case (i_cmd.op)
                            OP_CLEAR: begin
                                r_lg    <= LW'(1);
                                r_live  <= '0;
                                r_never <= CW'(2);
                                r_st    <= ST_INIT;
                                r_ovalid <= 1'b1;
                            end
                            OP_NONE: begin
                                r_ovalid <= 1'b1;
                                r_st     <= ST_OUT;
                            end
                            default: r_st <= ST_LOOK_RD;
                        endcase
                    end
                end
                ST_LOOK_RD: begin
                    if (r_n == w_bound) begin
                        r_st <= ST_DECIDE;
                    end else begin
                        r_idx   <= w_slot;
                        r_mk_rd <= r_mkey[w_slot];
                        r_mv_rd <= r_mval[w_slot];
                        r_st    <= ST_LOOK_CHK;
                    end
                end
                ST_LOOK_CHK: begin
                    if (r_mk_rd == r_cmd.key) begin
                        r_found <= 1'b1;
                        r_res   <= r_mv_rd;
                        unique case (r_cmd.op)
                            OP_REPLACE: begin
                                r_mval[r_idx] <= r_cmd.data;
                                r_st <= ST_OUT;
                                r_ovalid <= 1'b1;
                            end
                            OP_REMOVE: begin
                                r_mkey[r_idx] <= KEY_TOMB;
                                r_mval[r_idx] <= '0;
                                r_live <= r_live - CW'(1);
                                if (((r_live - CW'(1)) < (w_size >> 2)) && (r_lg > LW'(1))) begin
                                    r_newlg <= r_lg - LW'(1);
                                    r_from_place <= 1'b0;
                                    r_i  <= '0;
                                    r_st <= ST_RS_CLR;
                                end else begin
                                    r_st <= ST_OUT;
                                    r_ovalid <= 1'b1;
                                end
                            end
                            default: begin
                                r_st <= ST_OUT;
                                r_ovalid <= 1'b1;
                            end
                        endcase
                    end else if (r_mk_rd == KEY_EMPTY) begin
                        r_st <= ST_DECIDE;
                    end else begin
                        r_p  <= (r_p << 2) + r_p + r_b + KeyW'(1);
                        r_b  <= r_b >> 5;
                        r_n  <= r_n + (CW+5)'(1);
                        r_st <= ST_LOOK_RD;
                    end
                end
                ST_DECIDE: begin
                    // key absent: place for insert and replace
                    if (r_cmd.op == OP_INSERT || r_cmd.op == OP_REPLACE) begin
                        if ((r_never << 1) <= w_size) begin
                            if (r_lg < LW'(MAX_SLOTS_LOG2)) begin
                                r_newlg <= r_lg + LW'(1);
                                r_from_place <= 1'b1;
                                r_i  <= '0;
                                r_st <= ST_RS_CLR;
                            end else begin
                                r_fail <= 1'b1;
                                r_st <= ST_OUT;
                                r_ovalid <= 1'b1;
                            end
                        end else begin
                            r_p <= w_h;
                            r_b <= w_h;
                            r_n <= '0;
                            r_st <= ST_PLACE_RD;
                        end
                    end else begin
                        r_st <= ST_OUT;
                        r_ovalid <= 1'b1;
                    end
                end
                ST_PLACE_RD: begin
                    if (r_n == w_bound) begin
                        r_st <= ST_OUT;
                        r_ovalid <= 1'b1;
                    end else begin
                        r_idx   <= w_slot;
                        r_mk_rd <= r_mkey[w_slot];
                        r_st    <= ST_PLACE_CHK;
                    end
                end
                ST_PLACE_CHK: begin
                    if (r_mk_rd == KEY_EMPTY || r_mk_rd == KEY_TOMB) begin
                        if (r_mk_rd == KEY_EMPTY) r_never <= r_never - CW'(1);
                        r_live <= r_live + CW'(1);
                        r_mkey[r_idx] <= r_cmd.key;
                        r_mval[r_idx] <= r_cmd.data;
                        r_res <= (r_cmd.op == OP_INSERT) ? r_cmd.data : '0;
                        r_st <= ST_OUT;
                        r_ovalid <= 1'b1;
                    end else begin
                        r_p  <= (r_p << 2) + r_p + r_b + KeyW'(1);
                        r_b  <= r_b >> 5;
                        r_n  <= r_n + (CW+5)'(1);
                        r_st <= ST_PLACE_RD;
                    end
                end
                ST_RS_CLR: begin
                    // clear scratch over the new size
                    r_skey[AW'(r_i)] <= KEY_EMPTY;
                    r_sval[AW'(r_i)] <= '0;
                    if (r_i == w_news - CW'(1)) begin
                        r_i  <= '0;
                        r_st <= ST_RS_SCAN_RD;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                ST_RS_SCAN_RD: begin
                    if (r_i == w_size) begin
                        r_i  <= '0;
                        r_st <= ST_RS_COPY_RD;
                    end else begin
                        r_rkey <= r_mkey[AW'(r_i)];
                        r_rval <= r_mval[AW'(r_i)];
                        r_st   <= ST_RS_SCAN_CHK;
                    end
                end
                ST_RS_SCAN_CHK: begin
                    if (r_rkey != KEY_EMPTY && r_rkey != KEY_TOMB) begin
                        r_p  <= w_rh;
                        r_b  <= w_rh;
                        r_n  <= '0;
                        r_st <= ST_RS_PRB_RD;
                    end else begin
                        r_i  <= r_i + CW'(1);
                        r_st <= ST_RS_SCAN_RD;
                    end
                end
                ST_RS_PRB_RD: begin
                    if (r_n == w_nbound) begin
                        r_i  <= r_i + CW'(1);
                        r_st <= ST_RS_SCAN_RD;
                    end else begin
                        r_idx   <= w_nslot;
                        r_sk_rd <= r_skey[w_nslot];
                        r_st    <= ST_RS_PRB_CHK;
                    end
                end
                ST_RS_PRB_CHK: begin
                    if (r_sk_rd == KEY_EMPTY) begin
                        r_skey[r_idx] <= r_rkey;
                        r_sval[r_idx] <= r_rval;
                        r_i  <= r_i + CW'(1);
                        r_st <= ST_RS_SCAN_RD;
                    end else begin
                        r_p  <= (r_p << 2) + r_p + r_b + KeyW'(1);
                        r_b  <= r_b >> 5;
                        r_n  <= r_n + (CW+5)'(1);
                        r_st <= ST_RS_PRB_RD;
                    end
                end
                ST_RS_COPY_RD: begin
                    // copy scratch back over the whole storage
                    r_sk_rd <= r_skey[AW'(r_i)];
                    r_sv_rd <= r_sval[AW'(r_i)];
                    r_idx   <= AW'(r_i);
                    r_st    <= ST_RS_COPY_WR;
                end
                ST_RS_COPY_WR: begin
                    if (r_i < w_news) begin
                        r_mkey[r_idx] <= r_sk_rd;
                        r_mval[r_idx] <= r_sv_rd;
                    end else begin
                        r_mkey[r_idx] <= KEY_EMPTY;
                        r_mval[r_idx] <= '0;
                    end
                    if (r_i == CW'(Slots - 1)) begin
                        r_lg    <= r_newlg;
                        r_never <= w_news - r_live;
                        if (r_from_place) begin
                            r_p  <= w_h;
                            r_b  <= w_h;
                            r_n  <= '0;
                            r_st <= ST_PLACE_RD;
                        end else begin
                            r_st <= ST_OUT;
                            r_ovalid <= 1'b1;
                        end
                    end else begin
                        r_i  <= r_i + CW'(1);
                        r_st <= ST_RS_COPY_RD;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || m_axis_tready) r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== src/open_address_hash_map.sv =====
// A lookup walks the probe chain to a match or an empty slot; a placement walks it
// again to a free slot. Clear and illegal items give their result without a walk.
// A resize clears the scratch table over the new size, rehashes the live entries
// into it and copies the scratch back over the whole storage.
// The engine takes one item at a time: a new item is taken only once the
// previous result has left. Reset and clear run a clearing pass over the main table.
// ---------------------------------------------------------------------------
// open_address_hash_map: open-addressed key to data map
// Front intake queue feeding a sequential table engine.
// ---------------------------------------------------------------------------
module open_address_hash_map #(
    parameter int MAX_SLOTS_LOG2 = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // req_type[2:0], key[66:3], write_data[130:67]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // result_data[63:0], key_found[64], grow_failed[65]
);
    import oahm_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid, w_cmd_ready;

    // intake and classification
    oahm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_ready  (w_cmd_ready),
        .o_cmd        (w_cmd)
    );

    // table engine
    oahm_back #(.MAX_SLOTS_LOG2(MAX_SLOTS_LOG2)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_ready  (w_cmd_ready),
        .i_cmd        (w_cmd),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule

// ===== test/oahm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oahm_checker: result predictor and scoreboard for the hash map
// Watches both stream channels, keeps its own copy of the table, works out
// the answer to every accepted request and compares each returned item.
// ---------------------------------------------------------------------------
module oahm_checker #(
    parameter int MAX_SLOTS_LOG2 = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [135:0] i_s_tdata,  // req_type[2:0], key[66:3], write_data[130:67]
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [71:0]  i_m_tdata,  // result_data[63:0], key_found[64], grow_failed[65]
    output int           o_fail_count,
    output int           o_pending
);
    import oahm_pkg::*;

    localparam int NSlots = 1 << MAX_SLOTS_LOG2;

    typedef struct packed {
        logic [DataW-1:0] data;
        logic             found;
        logic             failed;
    } t_answer;

    // predicted table contents
    logic [KeyW-1:0]  tbl_key [NSlots];
    logic [DataW-1:0] tbl_val [NSlots];
    logic [KeyW-1:0]  new_key [NSlots];
    logic [DataW-1:0] new_val [NSlots];
    int unsigned      tbl_lg;
    int unsigned      live_cnt;
    int unsigned      fresh_cnt;

    t_answer answers_due[$];
    int      result_no;

    localparam int WALK_BOUND = 0;
    localparam int WALK_MATCH = 1;
    localparam int WALK_EMPTY = 2;
    localparam int WALK_TOMB  = 3;

    function automatic bit key_legal(logic [KeyW-1:0] k);
        return k != KEY_EMPTY && k != KEY_TOMB;
    endfunction

    // probe walk over the live table or the rehash scratch table
    function automatic int probe_walk(bit scratch, int unsigned lg, logic [KeyW-1:0] k,
                                      bit want_key, bit take_tomb, output int unsigned idx);
        logic [63:0]     p;
        logic [63:0]     b;
        logic [KeyW-1:0] sk;
        int unsigned     sz;
        sz  = 1 << lg;
        p   = k ^ (k >> 13);
        b   = p;
        idx = 0;
        for (int unsigned n = 0; n < sz + 16; n++) begin
            idx = p & (sz - 1);
            sk  = scratch ? new_key[idx] : tbl_key[idx];
            if (want_key && sk == k) return WALK_MATCH;
            if (sk == KEY_EMPTY) return WALK_EMPTY;
            if (take_tomb && sk == KEY_TOMB) return WALK_TOMB;
            p = p * 64'd5 + b + 64'd1;
            b = b >> 5;
        end
        return WALK_BOUND;
    endfunction

    // rebuild the live entries into a table of the new size
    function automatic void rebuild(int unsigned lg);
        int unsigned x;
        for (int i = 0; i < NSlots; i++) begin
            new_key[i] = '0;
            new_val[i] = '0;
        end
        for (int i = 0; i < (1 << tbl_lg); i++) begin
            if (key_legal(tbl_key[i]) &&
                probe_walk(1'b1, lg, tbl_key[i], 1'b0, 1'b0, x) == WALK_EMPTY) begin
                new_key[x] = tbl_key[i];
                new_val[x] = tbl_val[i];
            end
        end
        for (int i = 0; i < NSlots; i++) begin
            tbl_key[i] = new_key[i];
            tbl_val[i] = new_val[i];
        end
        tbl_lg    = lg;
        fresh_cnt = (1 << lg) - live_cnt;
    endfunction

    function automatic void wipe_table();
        for (int i = 0; i < NSlots; i++) begin
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
        tbl_lg    = 1;
        live_cnt  = 0;
        fresh_cnt = 2;
    endfunction

    // work out the answer to one request and update the table copy
    function automatic t_answer serve_request(logic [ReqW-1:0] req, logic [KeyW-1:0] k,
                                              logic [DataW-1:0] wd);
        t_answer     a;
        int unsigned x;
        int          r;
        int unsigned sz;
        bit          ok;
        a  = '0;
        sz = 1 << tbl_lg;
        if (req == REQ_CLEAR) begin
            wipe_table();
        end else if (req <= REQ_FIND && key_legal(k)) begin
            r = probe_walk(1'b0, tbl_lg, k, 1'b1, 1'b0, x);
            if (r == WALK_MATCH) begin
                a.found = 1'b1;
                a.data  = tbl_val[x];
                if (req == REQ_REPLACE) begin
                    tbl_val[x] = wd;
                end else if (req == REQ_REMOVE) begin
                    tbl_key[x] = KEY_TOMB;
                    tbl_val[x] = '0;
                    live_cnt--;
                    if (live_cnt < (sz >> 2) && tbl_lg > 1) rebuild(tbl_lg - 1);
                end
            end else if (req == REQ_INSERT || req == REQ_REPLACE) begin
                ok = 1'b1;
                if (fresh_cnt * 2 <= sz) begin
                    if (tbl_lg < MAX_SLOTS_LOG2) begin
                        rebuild(tbl_lg + 1);
                    end else begin
                        ok       = 1'b0;
                        a.failed = 1'b1;
                    end
                end
                if (ok) begin
                    r = probe_walk(1'b0, tbl_lg, k, 1'b0, 1'b1, x);
                    if (r == WALK_EMPTY || r == WALK_TOMB) begin
                        if (r == WALK_EMPTY) fresh_cnt--;
                        live_cnt++;
                        tbl_key[x] = k;
                        tbl_val[x] = wd;
                        a.data     = (req == REQ_INSERT) ? wd : '0;
                    end
                end
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("result %0d: %s got %h want %h", result_no, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        result_no    = 0;
        wipe_table();
    end

    assign o_pending = answers_due.size();

    // predict on each accepted request, compare each returned item
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                answers_due.push_back(serve_request(i_s_tdata[2:0], i_s_tdata[66:3],
                                                    i_s_tdata[130:67]));
            if (i_m_tvalid && i_m_tready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected item", i_m_tdata[63:0], '0);
                end else begin
                    want = answers_due.pop_front();
                    if (i_m_tdata[63:0] !== want.data)
                        report_mismatch("result_data", i_m_tdata[63:0], want.data);
                    if (i_m_tdata[64] !== want.found)
                        report_mismatch("key_found", i_m_tdata[64], want.found);
                    if (i_m_tdata[65] !== want.failed)
                        report_mismatch("grow_failed", i_m_tdata[65], want.failed);
                end
                result_no++;
            end
        end
    end

endmodule

// ===== test/tb_open_address_hash_map.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_open_address_hash_map: stimulus and verdict for the hash map
// Drives directed and random requests, fills the table to its maximum size,
// removes part of it again, and leaves all checking to the attached checker.
// ---------------------------------------------------------------------------
module tb_open_address_hash_map;
    import oahm_pkg::*;

    localparam int  MaxLg      = 10;
    localparam int  CycleLimit = 5000000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;   // req_type[2:0], key[66:3], write_data[130:67]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;   // result_data[63:0], key_found[64], grow_failed[65]

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_wanted;
    int cycle_count;

    logic [KeyW-1:0] key_pool[40];
    logic [KeyW-1:0] fill_keys[$];

    open_address_hash_map #(.MAX_SLOTS_LOG2(MaxLg)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    oahm_checker #(.MAX_SLOTS_LOG2(MaxLg)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CycleLimit) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random stalls, and one long hold-off while the sender keeps going
    initial begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                hold_left   = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // offer one item, called at a falling edge, returns at a falling edge
    task automatic send_item(logic [ReqW-1:0] req, logic [KeyW-1:0] k, logic [DataW-1:0] wd);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, wd, k, req};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one random request, mostly on pooled keys so hits are common
    task automatic send_random();
        int              r;
        logic [KeyW-1:0] k;
        r = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, 39)];
        if (r < 30)      send_item(REQ_INSERT, k, rand64());
        else if (r < 45) send_item(REQ_REPLACE, k, rand64());
        else if (r < 65) send_item(REQ_REMOVE, k, rand64());
        else if (r < 90) send_item(REQ_FIND, k, rand64());
        else if (r < 92) send_item(REQ_CLEAR, rand64(), rand64());
        else if (r < 95) send_item(3'($urandom_range(0, 3)), ($urandom_range(0, 1) ? '1 : '0),
                                   rand64());
        else if (r < 97) send_item(3'($urandom_range(5, 7)), k, rand64());
        else             send_item(3'($urandom_range(0, 3)), rand64(), rand64());
    endtask

    initial begin
        logic [KeyW-1:0] k;
        int              n_rand;
        send_idle_pct = 35;
        recv_idle_pct = 63;
        hold_wanted   = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        for (int i = 0; i < 40; i++)
            key_pool[i] = (i < 20) ? rand64() : 64'(i - 19);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: hits, misses, illegal keys, unused codes, clear
        send_item(REQ_INSERT, 64'h1234_5678_9abc_def0, 64'hffff_ffff_ffff_ffff);
        send_item(REQ_INSERT, 64'h1234_5678_9abc_def0, 64'h1);
        send_item(REQ_REPLACE, 64'h1234_5678_9abc_def0, 64'h0);
        send_item(REQ_REPLACE, 64'hffff_ffff_ffff_fffe, 64'haaaa_5555_aaaa_5555);
        send_item(REQ_INSERT, 64'h1, 64'h5555_aaaa_5555_aaaa);
        send_item(REQ_FIND, 64'h1234_5678_9abc_def0, '0);
        send_item(REQ_FIND, 64'h8000_0000_0000_0000, '0);
        send_item(REQ_FIND, 64'hffff_ffff_ffff_fffe, '0);
        send_item(REQ_REMOVE, 64'h1234_5678_9abc_def0, '0);
        send_item(REQ_REMOVE, 64'h1234_5678_9abc_def0, '0);
        send_item(REQ_FIND, 64'h1234_5678_9abc_def0, '0);
        send_item(REQ_INSERT, KEY_EMPTY, 64'h77);
        send_item(REQ_REPLACE, KEY_TOMB, 64'h77);
        send_item(REQ_FIND, KEY_TOMB, '0);
        send_item(REQ_REMOVE, KEY_EMPTY, '0);
        send_item(3'd5, 64'h1, '1);
        send_item(3'd6, 64'h1, '1);
        send_item(3'd7, '1, '1);
        send_item(REQ_CLEAR, 64'h1, '1);
        send_item(REQ_FIND, 64'h1, '0);
        send_item(REQ_INSERT, 64'h1, '1);

        // random mix, sender sparse and receiver busy
        for (n_rand = 0; n_rand < 130; n_rand++) send_random();

        // roles swapped, with one long receiver hold-off up front
        send_idle_pct = 63;
        recv_idle_pct = 35;
        hold_wanted   = 1'b1;
        for (n_rand = 0; n_rand < 60; n_rand++) send_random();

        // fill up to the largest table, then run into grow failures
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_item(REQ_CLEAR, '0, '0);
        for (int i = 0; i < 540; i++) begin
            k = rand64();
            fill_keys.push_back(k);
            send_item($urandom_range(0, 1) ? REQ_INSERT : REQ_REPLACE, k, rand64());
        end
        send_item(REQ_INSERT, fill_keys[3], rand64());
        send_item(REQ_REPLACE, fill_keys[7], rand64());
        send_item(REQ_FIND, fill_keys[11], '0);

        // remove every third fill key, then look up every fifth
        for (int i = 0; i < 540; i += 3) send_item(REQ_REMOVE, fill_keys[i], '0);
        for (int i = 1; i < 540; i += 5) send_item(REQ_FIND, fill_keys[i], '0);

        for (n_rand = 0; n_rand < 50; n_rand++) send_random();
        s_axis_tvalid <= 1'b0;

        // wait for the last results
        while (pending > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/oahm_pkg.sv
src/oahm_front.sv
src/oahm_back.sv
src/open_address_hash_map.sv
test/oahm_checker.sv
test/tb_open_address_hash_map.sv
